[rtl/pps_pkg.sv]
package pps_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned COORD_W          = 16;
  localparam int unsigned VY_W             = 17;
  localparam int unsigned HEIGHT_W         = 15;
  localparam int unsigned TOTAL_W          = 7;

  localparam logic CFG_SCREEN_HEIGHT = 1'b0;
  localparam logic CFG_KEEP_INSIDE   = 1'b1;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_TEST   = 2'd2
  } func_e;

  typedef struct packed {
    logic signed [VY_W-1:0]    y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic start;
    logic valid;
    logic first;
    logic close;
  } edge_ctl_t;

  typedef struct packed {
    logic               overflow;
    logic [TOTAL_W-1:0] total;
    logic               hide;
    logic               in_poly;
  } result_t;

endpackage

[rtl/pps_cell.sv]
module pps_cell import pps_pkg::*; (
  input  logic    clk_i,
  input  logic    shift_i,
  input  vertex_t vtx_i,
  output vertex_t vtx_o
);

  vertex_t vtx_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vtx_q <= vtx_i;
    end
  end

  assign vtx_o = vtx_q;

endmodule

[rtl/pps_edge.sv]
module pps_edge import pps_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  edge_ctl_t                 ctl_i,
  input  vertex_t                   vtx_i,
  input  logic signed [COORD_W-1:0] px_i,
  input  logic signed [COORD_W-1:0] py_i,
  output logic                      done_o,
  output logic                      inside_o
);

  // stage 0: edge formation
  vertex_t first_q, prev_q, e_a_q, e_b_q;
  logic    e_vld_q, e_last_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prev_q <= vtx_i;
      if (ctl_i.first) begin
        first_q <= vtx_i;
      end
    end
    e_a_q <= prev_q;
    e_b_q <= ctl_i.close ? first_q : vtx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q  <= 1'b0;
      e_last_q <= 1'b0;
    end else begin
      e_vld_q  <= (ctl_i.valid && !ctl_i.first) || ctl_i.close;
      e_last_q <= ctl_i.close;
    end
  end

  // stage 1: crossing test and cross-product terms
  logic signed [VY_W:0]      ay, by, py, dy_ab, dy_pb;
  logic signed [COORD_W:0]   dx_pb, dx_ab;
  logic signed [34:0]        p1_d, p2_d, p1_q, p2_q;
  logic                      cross_d, cross_q, aby_neg_q;
  logic                      s1_vld_q, s1_last_q;

  assign ay    = {e_a_q.y[VY_W-1], e_a_q.y};
  assign by    = {e_b_q.y[VY_W-1], e_b_q.y};
  assign py    = {{2{py_i[COORD_W-1]}}, py_i};
  assign dy_ab = ay - by;
  assign dy_pb = py - by;
  assign dx_pb = {px_i[COORD_W-1], px_i} - {e_b_q.x[COORD_W-1], e_b_q.x};
  assign dx_ab = {e_a_q.x[COORD_W-1], e_a_q.x} - {e_b_q.x[COORD_W-1], e_b_q.x};
  assign p1_d  = dx_pb * dy_ab;
  assign p2_d  = dx_ab * dy_pb;
  assign cross_d = ((by <= py) && (py < ay)) || ((ay <= py) && (py < by));

  always_ff @(posedge clk_i) begin
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    cross_q   <= cross_d;
    aby_neg_q <= (ay < by);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= e_vld_q;
      s1_last_q <= e_last_q;
    end
  end

  // stage 2: parity accumulate
  logic signed [35:0] t;
  logic               neg;
  logic               parity_q, done_q;

  assign t   = {p1_q[34], p1_q} - {p2_q[34], p2_q};
  assign neg = aby_neg_q ? (!t[35] && (t != '0)) : t[35];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= s1_vld_q && s1_last_q;
      if (ctl_i.start) begin
        parity_q <= 1'b0;
      end else if (s1_vld_q && cross_q && neg) begin
        parity_q <= !parity_q;
      end
    end
  end

  assign done_o   = done_q;
  assign inside_o = parity_q;

endmodule

[rtl/polygon_point_selector.sv]
// Polygon point selector. Each input transaction clears the polygon, appends a vertex
// (y flipped as screen_height - y) or tests a point against the polygon with the even-odd
// crossing rule. Vertices sit in a ring of MAX_VERTICES cells; a test rotates the whole
// ring once past one edge evaluator whatever the vertex count, while clear, append and
// tests on fewer than two vertices give their result without a sweep. One transaction is
// in work at a time; one finished result can wait in a holding register behind a stalled
// output register.
module polygon_point_selector import pps_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // coord_x[15:0], coord_y[31:16]
  input  logic [1:0]          s_axis_tuser,  // func
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // point_inside, hide_point, vertex_total[8:2],
                                             // overflow[9], zeros above
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [HEIGHT_W-1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IdxW = $clog2(MAX_VERTICES);
  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_CLOSE = 4'b0100,
    ST_WAIT  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [IdxW-1:0]     k_q, k_d;
  logic [HEIGHT_W-1:0] height_q;
  logic                keep_q;
  result_t             res_q, res_d, out_q;
  logic                res_vld_q, res_vld_d, out_vld_q;
  logic signed [COORD_W-1:0] px_q, py_q;

  logic                      accept, shift, full, load_out;
  logic signed [COORD_W-1:0] cx, cy;
  logic [VY_W:0]             flip_y;
  vertex_t                   head, new_vtx;
  vertex_t                   ring [MAX_VERTICES];
  logic [SumW-1:0]           pos;
  edge_ctl_t                 ctl;
  logic                      done, in_poly;

  assign cx      = s_axis_tdata[15:0];
  assign cy      = s_axis_tdata[31:16];
  assign flip_y  = {3'b000, height_q} - {{2{cy[COORD_W-1]}}, cy};
  assign new_vtx = '{y: flip_y[VY_W-1:0], x: cx};
  assign full    = (cnt_q == CntW'(MAX_VERTICES));

  assign s_axis_tready = (state_q == ST_IDLE) && !res_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos = SumW'(k_q) + SumW'(cnt_q);
  assign ctl.start = accept && (s_axis_tuser == FUNC_TEST) && (cnt_q >= CntW'(2));
  assign ctl.valid = (state_q == ST_SWEEP) && (pos >= SumW'(MAX_VERTICES));
  assign ctl.first = (pos == SumW'(MAX_VERTICES));
  assign ctl.close = (state_q == ST_CLOSE);

  assign head = (state_q == ST_SWEEP) ? ring[MAX_VERTICES-1] : new_vtx;

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .vtx_i   ((i == 0) ? head : ring[(i == 0) ? 0 : i-1]),
      .vtx_o   (ring[i])
    );
  end

  pps_edge u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .vtx_i    (ring[MAX_VERTICES-1]),
    .px_i     (px_q),
    .py_i     (py_q),
    .done_o   (done),
    .inside_o (in_poly)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    res_d     = res_q;
    res_vld_d = res_vld_q && !load_out;
    shift     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d     = '{overflow: 1'b0, total: TOTAL_W'(cnt_q), hide: 1'b0, in_poly: 1'b0};
          res_vld_d = 1'b1;
          case (s_axis_tuser)
            FUNC_CLEAR: begin
              cnt_d       = '0;
              res_d.total = '0;
            end
            FUNC_APPEND: begin
              if (full) begin
                res_d.overflow = 1'b1;
              end else begin
                shift       = 1'b1;
                cnt_d       = cnt_q + 1'b1;
                res_d.total = TOTAL_W'(cnt_d);
              end
            end
            FUNC_TEST: begin
              if (cnt_q >= CntW'(2)) begin
                res_vld_d = 1'b0;
                k_d       = '0;
                state_d   = ST_SWEEP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        shift = 1'b1;
        k_d   = k_q + 1'b1;
        if (k_q == IdxW'(MAX_VERTICES - 1)) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (done) begin
          res_d     = '{overflow: 1'b0, total: TOTAL_W'(cnt_q), hide: in_poly ^ keep_q,
                        in_poly: in_poly};
          res_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign load_out = res_vld_q && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      k_q       <= '0;
      res_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      height_q  <= HEIGHT_W'(1);
      keep_q    <= 1'b1;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      res_vld_q <= res_vld_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
          CFG_KEEP_INSIDE:   keep_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
    if (accept) begin
      px_q <= cx;
      py_q <= cy;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b000000, out_q};

endmodule

[rtl/pps_checker.sv]
module pps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one transaction in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted back to back");

  // a dropped append carries no test flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> !m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("overflow with test flags");

  // unused tdata bits stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:10] == 6'b000000))
    else $error("padding bits set");

endmodule

bind polygon_point_selector pps_checker u_pps_checker (.*);

[verif/polygon_point_selector_tb.sv]
`timescale 1ns / 100ps

module polygon_point_selector_tb import pps_pkg::*;;

  localparam int unsigned MAX_VERTICES = MAX_VERTICES_DEF;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;   // coord_x[15:0], coord_y[31:16]
  logic [1:0]          s_axis_tuser = '0;   // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // point_inside, hide_point, vertex_total[8:2],
                                            // overflow[9], zeros above
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [HEIGHT_W-1:0] cfg_wdata_i = '0;

  polygon_point_selector #(.MAX_VERTICES(MAX_VERTICES)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [HEIGHT_W-1:0]     screen_height = 15'd1;
  logic                    keep_inside = 1'b1;
  logic signed [COORD_W-1:0] vert_x [MAX_VERTICES];
  logic signed [VY_W-1:0]    vert_y [MAX_VERTICES];
  int unsigned             vert_count = 0;

  result_t     pending_selector_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned error_count = 0;

  function automatic bit point_in_polygon(longint px, longint py);
    longint ax, ay, bx, by, dy, cp;
    int unsigned k;
    bit parity;
    parity = 1'b0;
    ax = vert_x[0];
    ay = vert_y[0];
    for (int unsigned i = 1; i <= vert_count; i++) begin
      k = (i == vert_count) ? 0 : i;
      bx = vert_x[k];
      by = vert_y[k];
      if ((by <= py && py < ay) || (ay <= py && py < by)) begin
        dy = ay - by;
        cp = (px - bx) * dy - (ax - bx) * (py - by);
        if (dy < 0) cp = -cp;
        if (cp < 0) parity = ~parity;
      end
      ax = bx;
      ay = by;
    end
    return parity;
  endfunction

  function automatic result_t predict_selection(logic [1:0] func, logic signed [15:0] x,
                                                logic signed [15:0] y);
    result_t res;
    res = '0;
    case (func)
      FUNC_CLEAR: vert_count = 0;
      FUNC_APPEND: begin
        if (vert_count < MAX_VERTICES) begin
          vert_x[vert_count] = x;
          vert_y[vert_count] = VY_W'(longint'(screen_height) - longint'(y));
          vert_count++;
        end else begin
          res.overflow = 1'b1;
        end
      end
      FUNC_TEST: begin
        if (vert_count >= 2) begin
          res.in_poly = point_in_polygon(x, y);
          res.hide = (res.in_poly != keep_inside);
        end
      end
      default: ;
    endcase
    res.total = TOTAL_W'(vert_count);
    return res;
  endfunction

  function automatic logic signed [15:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] near_coord(longint c, int unsigned r);
    return clamp_coord(c + longint'($urandom_range(2 * r)) - longint'(r));
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_selector_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_selector_results.pop_front();
        got = m_axis_tdata[9:0];
        compare_field("point_inside", 8'(want.in_poly), 8'(got.in_poly));
        compare_field("hide_point", 8'(want.hide), 8'(got.hide));
        compare_field("vertex_total", 8'(want.total), 8'(got.total));
        compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
        compare_field("padding", 8'd0, 8'(m_axis_tdata[15:10]));
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic [1:0] func, logic signed [15:0] x, logic signed [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_selector_results = {pending_selector_results, predict_selection(func, x, y)};
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_selector_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [HEIGHT_W-1:0] value);
    wait_for_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCREEN_HEIGHT) screen_height = value;
    else keep_inside = value[0];
  endtask

  // reset values: height 1, keep inside
  task automatic test_empty_polygon();
    send_item(FUNC_TEST, 16'sd0, 16'sd0);
    send_item(FUNC_TEST, 16'sh8000, 16'sh7fff);
    send_item(FUNC_UNUSED, 16'sh7fff, 16'sh8000);
    send_item(FUNC_APPEND, 16'sh8000, 16'sh8000);
    send_item(FUNC_TEST, 16'sh8000, 16'sh7fff);
    send_item(FUNC_CLEAR, 16'shffff, 16'shffff);
  endtask

  // full-range square in flipped coordinates, both keep modes
  task automatic test_square_polygon();
    write_register(CFG_SCREEN_HEIGHT, 15'h7fff);
    write_register(CFG_KEEP_INSIDE, 15'd1);
    send_item(FUNC_APPEND, 16'sh8000, 16'sh7fff);
    send_item(FUNC_APPEND, 16'sh7fff, 16'sh7fff);
    send_item(FUNC_APPEND, 16'sh7fff, 16'sh8000);
    send_item(FUNC_APPEND, 16'sh8000, 16'sh8000);
    send_item(FUNC_TEST, 16'sd0, 16'sd100);
    send_item(FUNC_TEST, 16'sh8000, 16'sd0);
    send_item(FUNC_TEST, 16'sh7fff, 16'sh7fff);
    send_item(FUNC_TEST, 16'sd0, 16'sh8000);
    send_item(FUNC_TEST, 16'sh8000, 16'sh8000);
    send_item(FUNC_UNUSED, 16'sd0, 16'sd0);
    write_register(CFG_KEEP_INSIDE, 15'd0);
    send_item(FUNC_TEST, 16'sd5, 16'sd5);
    send_item(FUNC_TEST, 16'sd0, 16'sh8000);
    send_item(FUNC_CLEAR, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_polygons(logic [HEIGHT_W-1:0] height, logic keep,
                                      int unsigned n_items);
    int unsigned target, nverts, ntests, radius;
    longint cx, cy;
    logic signed [15:0] ty;
    write_register(CFG_SCREEN_HEIGHT, height);
    write_register(CFG_KEEP_INSIDE, 15'(keep));
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(19) == 0) begin
        send_item(2'($urandom), 16'($urandom), 16'($urandom));
        continue;
      end
      case ($urandom_range(9))
        0: nverts = $urandom_range(2);
        1: nverts = $urandom_range(MAX_VERTICES + 4, MAX_VERTICES - 2);
        default: nverts = $urandom_range(12, 3);
      endcase
      case ($urandom_range(3))
        0: radius = 32768;
        1: radius = $urandom_range(40, 1);
        default: radius = $urandom_range(3000, 50);
      endcase
      cx = longint'($signed(16'($urandom)));
      cy = longint'($signed(16'($urandom)));
      if ($urandom_range(9) != 0) send_item(FUNC_CLEAR, 16'($urandom), 16'($urandom));
      repeat (nverts) begin
        ty = near_coord(cy, radius);
        send_item(FUNC_APPEND, near_coord(cx, radius),
                  clamp_coord(longint'(screen_height) - longint'(ty)));
      end
      ntests = $urandom_range(16, 1);
      repeat (ntests) begin
        if ($urandom_range(9) == 0)
          send_item(FUNC_TEST, 16'($urandom), 16'($urandom));
        else
          send_item(FUNC_TEST, near_coord(cx, radius + radius / 4),
                    near_coord(cy, radius + radius / 4));
      end
      if ($urandom_range(49) == 0) wait_for_results();
    end
  endtask

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 37;
    recv_idle_pct = 59;
    test_empty_polygon();
    test_square_polygon();
    test_random_polygons(15'd0, 1'b1, 320);
    test_random_polygons(15'h7fff, 1'b0, 320);

    send_idle_pct = 59;
    recv_idle_pct = 37;
    test_random_polygons(15'd1, 1'b1, 320);
    test_random_polygons(15'($urandom_range(32767, 1)), 1'b0, 320);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_polygons(15'd480, 1'b1, 320);
    test_random_polygons(15'($urandom_range(32767, 1)), 1'($urandom), 300);

    wait_for_results();
    repeat (MAX_VERTICES + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/pps_edge.sv
rtl/polygon_point_selector.sv
rtl/pps_checker.sv
verif/polygon_point_selector_tb.sv
